// ===== rtl/kei_pkg.sv =====
// Shared types, constants and helper functions for the keyframe envelope block.
// No dependencies.
package kei_pkg;

    localparam int TIME_FRAC_BITS = 16;
    localparam int TW = TIME_FRAC_BITS + 1;
    localparam int VW = 32;
    localparam int EW = TW + VW;
    localparam int PW = (TW + 1) + (VW + 1);
    localparam int ACCW = 60;
    localparam int AREA_SH = TIME_FRAC_BITS + 1;

    localparam logic [TW-1:0] TIME_ONE = TW'(1) << TIME_FRAC_BITS;
    localparam logic signed [ACCW-1:0] AREA_RND = (ACCW'(1) << AREA_SH) - ACCW'(1);

    typedef logic [2:0] req_t;
    localparam req_t REQ_ADD   = 3'd0;
    localparam req_t REQ_REM   = 3'd1;
    localparam req_t REQ_GET   = 3'd2;
    localparam req_t REQ_START = 3'd3;
    localparam req_t REQ_INT   = 3'd4;

    typedef logic [2:0] stat_t;
    localparam stat_t STAT_OK       = 3'd0;
    localparam stat_t STAT_FULL     = 3'd1;
    localparam stat_t STAT_NOTFOUND = 3'd2;
    localparam stat_t STAT_FEW      = 3'd3;
    localparam stat_t STAT_EOT      = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_RD,
        S_ADD_CHK,
        S_ADD_PUT,
        S_RM_RD,
        S_RM_CHK,
        S_RM_SHRD,
        S_RM_SHWR,
        S_SMP_RD,
        S_SMP_CHK,
        S_SMP_END,
        S_ST_RD0,
        S_ST_RD1,
        S_ST_SET,
        S_IN_RD0,
        S_IN_RD1,
        S_IN_CHK,
        S_IN_A1,
        S_IN_A2,
        S_IN_SCAN_RD,
        S_IN_SCAN_CHK,
        S_IN_B1,
        S_IN_B2,
        S_LERP_MUL,
        S_LERP_DIV0,
        S_LERP_DIV,
        S_PIECE_MUL,
        S_PIECE_ACC,
        S_FIN
    } state_t;

    function automatic logic signed [TW:0] tdiff(input logic [TW-1:0] t1,
                                                 input logic [TW-1:0] t0);
        tdiff = $signed({1'b0, t1}) - $signed({1'b0, t0});
    endfunction

    function automatic logic signed [VW:0] vsum(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
        vsum = (VW+1)'(a) + (VW+1)'(b);
    endfunction

    function automatic logic signed [VW:0] vdiff(input logic signed [VW-1:0] b,
                                                 input logic signed [VW-1:0] a);
        vdiff = (VW+1)'(b) - (VW+1)'(a);
    endfunction

    function automatic logic signed [VW-1:0] sat_val(input logic signed [ACCW-1:0] v);
        logic [ACCW-VW:0] top;
        top = v[ACCW-1:VW-1];
        if ((top == '0) || (top == '1))
            sat_val = v[VW-1:0];
        else if (v[ACCW-1])
            sat_val = {1'b1, {(VW-1){1'b0}}};
        else
            sat_val = {1'b0, {(VW-1){1'b1}}};
    endfunction

endpackage

// ===== rtl/kei_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kei_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/kei_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module kei_div #(
    parameter int NW = 51,
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CNTW = $clog2(NW + 1);

    logic [DW:0]     rem_reg;
    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW:0]     rem_sh;
    logic [DW:0]     rem_sub;
    logic            fits;

    assign rem_sh  = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign fits    = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub : rem_sh;
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/keyframe_envelope_interp_integrate.sv =====
// Keyframe envelope: sorted key table, interpolation and trapezoid integration.
// Add and remove step through the moved or scanned keys; get scans keys and runs at most one
// divide; integrate scans keys, accumulates trapezoids and runs at most one divide.
// One request at a time; in_stall is high from accept until the result beat is loaded.
// Each request is limited by the key table scan through the RAM read port and by the serial divider.
// Reset (async, active low) clears key count and cursor; key RAM contents stay undefined.
module keyframe_envelope_interp_integrate #(
    parameter int MAX_KEYS = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [2:0]                             req_type,
    input  logic [kei_pkg::TW-1:0]                 key_time,
    input  logic signed [kei_pkg::VW-1:0]          key_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [kei_pkg::VW-1:0]          value_out,
    output logic signed [kei_pkg::VW-1:0]          area_out,
    output logic [$clog2(MAX_KEYS+1)-1:0]          keys_held,
    output logic [2:0]                             status
);

    import kei_pkg::*;

    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int AW = $clog2(MAX_KEYS);

    state_t state_reg, state_next, ret_reg;

    logic [CW-1:0]          count_reg;
    logic [TW-1:0]          ctime_reg;
    logic signed [VW-1:0]   cval_reg;
    logic signed [VW-1:0]   seglo_reg;
    logic signed [VW-1:0]   seghi_reg;
    logic [CW-1:0]          idx_reg;
    logic                   out_valid_reg;

    req_t                   req_reg;
    logic [TW-1:0]          t_reg;
    logic signed [VW-1:0]   kv_reg;
    logic [CW-1:0]          i_reg;
    logic [TW-1:0]          e_t0_reg;
    logic signed [VW-1:0]   e_v0_reg;
    logic [TW-1:0]          hi_t_reg;
    logic signed [VW-1:0]   smp_reg;
    stat_t                  stat_reg;
    logic signed [TW:0]     mul_a_reg;
    logic signed [VW:0]     mul_b_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [VW-1:0]   lerp_a_reg;
    logic signed [VW-1:0]   lerp_b_reg;
    logic [TW-1:0]          lerp_d_reg;
    logic signed [VW-1:0]   lres_reg;
    logic signed [VW-1:0]   value_out_reg;
    logic signed [VW-1:0]   area_out_reg;
    logic [CW-1:0]          keys_held_reg;
    stat_t                  status_reg;

    logic                   in_fire;
    logic                   out_free;
    logic [TW-1:0]          t_in;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [EW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [EW-1:0]          ram_rdata;
    logic [TW-1:0]          rd_t;
    logic signed [VW-1:0]   rd_v;
    logic [CW:0]            i_inc;
    logic [CW:0]            i_inc2;
    logic [CW:0]            count_ext;
    logic signed [PW-1:0]   prod_full;
    logic [PW-1:0]          div_dividend;
    logic                   div_start;
    logic                   div_done;
    logic [PW-1:0]          div_q;
    logic signed [PW:0]     q_signed;
    logic signed [ACCW-1:0] lerp_sum;
    logic signed [ACCW-1:0] acc_adj;
    logic signed [ACCW-1:0] area_q;
    logic                   int_bad;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign t_in      = (key_time > TIME_ONE) ? TIME_ONE : key_time;
    assign rd_t      = ram_rdata[EW-1:VW];
    assign rd_v      = ram_rdata[VW-1:0];
    assign i_inc     = {1'b0, i_reg} + 1'b1;
    assign i_inc2    = i_inc + 1'b1;
    assign count_ext = {1'b0, count_reg};
    assign prod_full = mul_a_reg * mul_b_reg;
    assign div_dividend = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign q_signed  = prod_reg[PW-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    assign lerp_sum  = ACCW'(lerp_a_reg) + ACCW'(q_signed);
    assign acc_adj   = acc_reg + (acc_reg[ACCW-1] ? AREA_RND : '0);
    assign area_q    = acc_adj >>> AREA_SH;
    assign int_bad   = (count_reg < CW'(2)) || (idx_reg == '0) || (idx_reg >= count_reg)
                       || (t_reg < ctime_reg);

    kei_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_KEYS)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kei_div #(
        .NW (PW),
        .DW (TW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (lerp_d_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = i_reg[AW-1:0];
        ram_wdata  = {t_reg, kv_reg};
        ram_raddr  = i_reg[AW-1:0];
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                priority case (req_reg)
                    REQ_ADD:
                    begin
                        if (count_reg >= CW'(MAX_KEYS))
                            state_next = S_FIN;
                        else if (count_reg == '0)
                            state_next = S_ADD_PUT;
                        else
                            state_next = S_ADD_RD;
                    end
                    REQ_REM:   state_next = (count_reg == '0) ? S_FIN : S_RM_RD;
                    REQ_GET:   state_next = (count_reg == '0) ? S_FIN : S_SMP_RD;
                    REQ_START: state_next = (count_reg < CW'(2)) ? S_FIN : S_ST_RD0;
                    REQ_INT:   state_next = int_bad ? S_FIN : S_IN_RD0;
                    default:   state_next = S_FIN;
                endcase
            end
            S_ADD_RD:
            begin
                ram_raddr  = AW'(i_reg - 1'b1);
                state_next = S_ADD_CHK;
            end
            S_ADD_CHK:
            begin
                if (rd_t > t_reg)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    state_next = (i_reg == CW'(1)) ? S_ADD_PUT : S_ADD_RD;
                end
                else
                begin
                    state_next = S_ADD_PUT;
                end
            end
            S_ADD_PUT:
            begin
                ram_we     = 1'b1;
                state_next = S_FIN;
            end
            S_RM_RD:
            begin
                state_next = S_RM_CHK;
            end
            S_RM_CHK:
            begin
                if (rd_t == t_reg)
                    state_next = (i_inc < count_ext) ? S_RM_SHRD : S_FIN;
                else
                    state_next = (i_inc < count_ext) ? S_RM_RD : S_FIN;
            end
            S_RM_SHRD:
            begin
                ram_raddr  = i_inc[AW-1:0];
                state_next = S_RM_SHWR;
            end
            S_RM_SHWR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                state_next = (i_inc2 < count_ext) ? S_RM_SHRD : S_FIN;
            end
            S_SMP_RD:
            begin
                state_next = S_SMP_CHK;
            end
            S_SMP_CHK:
            begin
                if ((i_reg == '0) && ((count_reg == CW'(1)) || (t_reg < rd_t)))
                    state_next = S_FIN;
                else if ((i_inc < count_ext) && (t_reg >= rd_t))
                    state_next = S_SMP_RD;
                else
                    state_next = S_LERP_MUL;
            end
            S_SMP_END:
            begin
                state_next = S_FIN;
            end
            S_ST_RD0:
            begin
                ram_raddr  = '0;
                state_next = S_ST_RD1;
            end
            S_ST_RD1:
            begin
                ram_raddr  = AW'(1);
                state_next = S_ST_SET;
            end
            S_ST_SET:
            begin
                state_next = S_FIN;
            end
            S_IN_RD0:
            begin
                ram_raddr  = AW'(idx_reg - 1'b1);
                state_next = S_IN_RD1;
            end
            S_IN_RD1:
            begin
                ram_raddr  = idx_reg[AW-1:0];
                state_next = S_IN_CHK;
            end
            S_IN_CHK:
            begin
                state_next = (t_reg <= rd_t) ? S_LERP_MUL : S_PIECE_MUL;
            end
            S_IN_A1:
            begin
                state_next = S_PIECE_MUL;
            end
            S_IN_A2:
            begin
                state_next = S_FIN;
            end
            S_IN_SCAN_RD:
            begin
                state_next = (i_reg < count_reg) ? S_IN_SCAN_CHK : S_FIN;
            end
            S_IN_SCAN_CHK:
            begin
                state_next = (rd_t <= t_reg) ? S_PIECE_MUL : S_LERP_MUL;
            end
            S_IN_B1:
            begin
                state_next = S_PIECE_MUL;
            end
            S_IN_B2:
            begin
                state_next = S_FIN;
            end
            S_LERP_MUL:
            begin
                state_next = S_LERP_DIV0;
            end
            S_LERP_DIV0:
            begin
                if (lerp_d_reg == '0)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_LERP_DIV;
                end
            end
            S_LERP_DIV:
            begin
                if (div_done)
                    state_next = ret_reg;
            end
            S_PIECE_MUL:
            begin
                state_next = S_PIECE_ACC;
            end
            S_PIECE_ACC:
            begin
                state_next = ret_reg;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ctime_reg     <= '0;
            cval_reg      <= '0;
            seglo_reg     <= '0;
            seghi_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_ADD_PUT:
                begin
                    count_reg <= count_reg + 1'b1;
                end
                S_RM_CHK:
                begin
                    if ((rd_t == t_reg) && !(i_inc < count_ext))
                        count_reg <= count_reg - 1'b1;
                end
                S_RM_SHWR:
                begin
                    if (!(i_inc2 < count_ext))
                        count_reg <= count_reg - 1'b1;
                end
                S_ST_SET:
                begin
                    seglo_reg <= e_v0_reg;
                    seghi_reg <= rd_v;
                    idx_reg   <= CW'(1);
                    ctime_reg <= e_t0_reg;
                    cval_reg  <= e_v0_reg;
                end
                S_IN_A2, S_IN_B2:
                begin
                    ctime_reg <= t_reg;
                    cval_reg  <= lres_reg;
                end
                S_IN_SCAN_CHK:
                begin
                    seglo_reg <= seghi_reg;
                    seghi_reg <= rd_v;
                    if (rd_t <= t_reg)
                    begin
                        ctime_reg <= rd_t;
                        cval_reg  <= rd_v;
                        idx_reg   <= i_reg;
                    end
                    else
                    begin
                        idx_reg <= i_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    req_reg <= req_type;
                    t_reg   <= t_in;
                    kv_reg  <= key_value;
                end
            end
            S_DISPATCH:
            begin
                acc_reg  <= '0;
                smp_reg  <= '0;
                i_reg    <= (req_reg == REQ_ADD) ? count_reg : '0;
                stat_reg <= STAT_OK;
                priority case (req_reg)
                    REQ_ADD:
                    begin
                        if (count_reg >= CW'(MAX_KEYS))
                            stat_reg <= STAT_FULL;
                    end
                    REQ_REM:
                    begin
                        if (count_reg == '0)
                            stat_reg <= STAT_NOTFOUND;
                    end
                    REQ_GET, REQ_START:
                    begin
                        if (count_reg < CW'(2) && (req_reg == REQ_START || count_reg == '0))
                            stat_reg <= STAT_FEW;
                    end
                    REQ_INT:
                    begin
                        if (count_reg < CW'(2))
                            stat_reg <= STAT_FEW;
                        else if ((idx_reg == '0) || (idx_reg >= count_reg))
                            stat_reg <= STAT_EOT;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_ADD_CHK:
            begin
                if (rd_t > t_reg)
                    i_reg <= i_reg - 1'b1;
            end
            S_RM_CHK:
            begin
                if (rd_t != t_reg)
                begin
                    if (i_inc < count_ext)
                        i_reg <= i_inc[CW-1:0];
                    else
                        stat_reg <= STAT_NOTFOUND;
                end
            end
            S_RM_SHWR:
            begin
                i_reg <= i_inc[CW-1:0];
            end
            S_SMP_CHK:
            begin
                if ((i_reg == '0) && ((count_reg == CW'(1)) || (t_reg < rd_t)))
                begin
                    smp_reg <= rd_v;
                end
                else if ((i_inc < count_ext) && (t_reg >= rd_t))
                begin
                    e_t0_reg <= rd_t;
                    e_v0_reg <= rd_v;
                    i_reg    <= i_inc[CW-1:0];
                end
                else
                begin
                    mul_a_reg  <= tdiff(t_reg, e_t0_reg);
                    mul_b_reg  <= vdiff(rd_v, e_v0_reg);
                    lerp_a_reg <= e_v0_reg;
                    lerp_b_reg <= rd_v;
                    lerp_d_reg <= rd_t - e_t0_reg;
                    ret_reg    <= S_SMP_END;
                end
            end
            S_SMP_END:
            begin
                smp_reg <= lres_reg;
            end
            S_ST_RD1:
            begin
                e_t0_reg <= rd_t;
                e_v0_reg <= rd_v;
            end
            S_IN_RD1:
            begin
                e_t0_reg <= rd_t;
            end
            S_IN_CHK:
            begin
                if (t_reg <= rd_t)
                begin
                    mul_a_reg  <= tdiff(t_reg, e_t0_reg);
                    mul_b_reg  <= vdiff(seghi_reg, seglo_reg);
                    lerp_a_reg <= seglo_reg;
                    lerp_b_reg <= seghi_reg;
                    lerp_d_reg <= rd_t - e_t0_reg;
                    ret_reg    <= S_IN_A1;
                end
                else
                begin
                    mul_a_reg <= tdiff(rd_t, ctime_reg);
                    mul_b_reg <= vsum(cval_reg, seghi_reg);
                    hi_t_reg  <= rd_t;
                    i_reg     <= idx_reg + 1'b1;
                    ret_reg   <= S_IN_SCAN_RD;
                end
            end
            S_IN_A1:
            begin
                mul_a_reg <= tdiff(t_reg, ctime_reg);
                mul_b_reg <= vsum(cval_reg, lres_reg);
                ret_reg   <= S_IN_A2;
            end
            S_IN_SCAN_RD:
            begin
                if (!(i_reg < count_reg))
                    stat_reg <= STAT_EOT;
            end
            S_IN_SCAN_CHK:
            begin
                if (rd_t <= t_reg)
                begin
                    mul_a_reg <= tdiff(rd_t, hi_t_reg);
                    mul_b_reg <= vsum(seghi_reg, rd_v);
                    hi_t_reg  <= rd_t;
                    i_reg     <= i_inc[CW-1:0];
                    ret_reg   <= S_IN_SCAN_RD;
                end
                else
                begin
                    mul_a_reg  <= tdiff(t_reg, hi_t_reg);
                    mul_b_reg  <= vdiff(rd_v, seghi_reg);
                    lerp_a_reg <= seghi_reg;
                    lerp_b_reg <= rd_v;
                    lerp_d_reg <= rd_t - hi_t_reg;
                    ret_reg    <= S_IN_B1;
                end
            end
            S_IN_B1:
            begin
                mul_a_reg <= tdiff(t_reg, hi_t_reg);
                mul_b_reg <= vsum(seglo_reg, lres_reg);
                ret_reg   <= S_IN_B2;
            end
            S_LERP_MUL, S_PIECE_MUL:
            begin
                prod_reg <= prod_full;
            end
            S_LERP_DIV0:
            begin
                if (lerp_d_reg == '0)
                    lres_reg <= lerp_b_reg;
            end
            S_LERP_DIV:
            begin
                if (div_done)
                    lres_reg <= sat_val(lerp_sum);
            end
            S_PIECE_ACC:
            begin
                acc_reg <= acc_reg + ACCW'(prod_reg);
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    if ((req_reg == REQ_START) || (req_reg == REQ_INT))
                        value_out_reg <= cval_reg;
                    else if (req_reg == REQ_GET)
                        value_out_reg <= smp_reg;
                    else
                        value_out_reg <= '0;
                    area_out_reg  <= sat_val(area_q);
                    keys_held_reg <= count_reg;
                    status_reg    <= stat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign area_out  = area_out_reg;
    assign keys_held = keys_held_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_KEYS))
        else $error("key count above table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1)
        || (count_reg == $past(count_reg) - 1'b1))
        else $error("key count moved by more than one");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_LERP_DIV))
        else $error("divider finished outside interpolation wait");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_stall)
        else $error("request accepted while sequencer not started");
`endif

endmodule
